FILE: sv/aatm_pkg.sv
// ----------------------------------------------------------------------------
// aatm_pkg
// Shared constants, tables and types for the axis-angle transform matrix block.
// ----------------------------------------------------------------------------
package aatm_pkg;

  localparam int FRAC_BITS_DEF    = 16;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_ENTRIES     = 24;

  localparam int CW = 34;
  localparam int ZW = 35;
  localparam int TW = 35;

  localparam longint TWO_PI_Q30  = 64'sd6746518852;
  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint GAIN_Q30    = 64'sd652032874;
  localparam longint ONE_Q30     = 64'sd1073741824;

  localparam logic [29:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76, 30'h01FFD55B,
    30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD, 30'h000FFFFF, 30'h0007FFFF,
    30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF, 30'h00007FFF, 30'h00003FFF, 30'h00001FFF,
    30'h00000FFF, 30'h000007FF, 30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F
  };

  typedef enum logic [1:0] {
    ROW_0 = 2'd0,
    ROW_1 = 2'd1,
    ROW_2 = 2'd2,
    ROW_T = 2'd3
  } row_t;

  typedef struct packed {
    logic [2:0][31:0] scale;
    logic [2:0][31:0] shift;
    logic [2:0][15:0] axis;
  } side_t;

  typedef struct packed {
    logic [2:0][2:0][31:0] e;
    logic [2:0][31:0]      shift;
  } mat_t;

endpackage

FILE: sv/axis_angle_transform_matrix.sv
// ----------------------------------------------------------------------------
// axis_angle_transform_matrix
// Builds the 4x4 scale, rotate and translate matrix of one node transform.
// ----------------------------------------------------------------------------
// Each input transaction carries scale, translation, a Q2.14 rotation axis and
// a Q16.16 angle. Each one produces four output transactions, rows 0 to 3, and
// out_last_row marks row 3, which carries the translation and 1.0 in column 3.
// The angle is reduced over 33 - FRAC_BITS stages, the CORDIC takes one stage
// per iteration (at most 24) and the matrix arithmetic takes five stages, ahead
// of the output row register that holds the finished matrix.
// A new transaction can enter on every cycle while the pipeline is not held, but
// the result channel moves one row per cycle while the receiver is ready, so the
// sustained rate is set by the output row register, four rows per transform.
// The whole pipeline holds once the output register has a matrix waiting and
// the last stage is full, until row 3 is taken; in_ready then drops.
// Reset clears every valid flag; no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module axis_angle_transform_matrix #(
  parameter int FRAC_BITS    = aatm_pkg::FRAC_BITS_DEF,
  parameter int CORDIC_STEPS = aatm_pkg::CORDIC_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_scale_x,
  input  logic [31:0] in_scale_y,
  input  logic [31:0] in_scale_z,
  input  logic [31:0] in_shift_x,
  input  logic [31:0] in_shift_y,
  input  logic [31:0] in_shift_z,
  input  logic [15:0] in_axis_x,
  input  logic [15:0] in_axis_y,
  input  logic [15:0] in_axis_z,
  input  logic [31:0] in_angle,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_row_index,
  output logic [31:0] out_col0,
  output logic [31:0] out_col1,
  output logic [31:0] out_col2,
  output logic [31:0] out_col3,
  output logic        out_last_row
);
  import aatm_pkg::*;

  logic                 adv;
  side_t                in_side;
  logic                 red_vld;
  logic signed [ZW-1:0] red_z;
  logic                 red_flip;
  side_t                red_side;
  logic                 cor_vld;
  logic signed [CW-1:0] cor_x;
  logic signed [CW-1:0] cor_y;
  logic                 cor_flip;
  side_t                cor_side;
  logic                 mat_vld;
  mat_t                 mat;

  assign in_side.scale = {in_scale_z, in_scale_y, in_scale_x};
  assign in_side.shift = {in_shift_z, in_shift_y, in_shift_x};
  assign in_side.axis  = {in_axis_z, in_axis_y, in_axis_x};
  assign in_ready      = adv;

  aatm_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_valid),
    .in_angle (in_angle),
    .in_side  (in_side),
    .out_vld  (red_vld),
    .out_z    (red_z),
    .out_flip (red_flip),
    .out_side (red_side)
  );

  aatm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (red_vld),
    .in_z     (red_z),
    .in_flip  (red_flip),
    .in_side  (red_side),
    .out_vld  (cor_vld),
    .out_x    (cor_x),
    .out_y    (cor_y),
    .out_flip (cor_flip),
    .out_side (cor_side)
  );

  aatm_matrix u_matrix (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (cor_vld),
    .in_x    (cor_x),
    .in_y    (cor_y),
    .in_flip (cor_flip),
    .in_side (cor_side),
    .out_vld (mat_vld),
    .out_mat (mat)
  );

  aatm_rows #(.FRAC_BITS(FRAC_BITS)) u_rows (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_vld        (mat_vld),
    .in_mat        (mat),
    .adv           (adv),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_row_index (out_row_index),
    .out_col0      (out_col0),
    .out_col1      (out_col1),
    .out_col2      (out_col2),
    .out_col3      (out_col3),
    .out_last_row  (out_last_row)
  );

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_last_row == (out_row_index == ROW_T)))
    else $error("last_row flag does not match row index");

  a_row_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_row |=>
      out_valid && (out_row_index == $past(out_row_index) + 2'd1))
    else $error("matrix rows left out of order");

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("pipeline stalled with an empty output register");

endmodule

FILE: sv/aatm_reduce.sv
// ----------------------------------------------------------------------------
// aatm_reduce
// Pipelined reduction of the angle into (-pi, pi] and fold into [-pi/2, pi/2].
// ----------------------------------------------------------------------------
module aatm_reduce #(
  parameter int FRAC_BITS = aatm_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [31:0]                    in_angle,
  input  aatm_pkg::side_t                in_side,
  output logic                           out_vld,
  output logic signed [aatm_pkg::ZW-1:0] out_z,
  output logic                           out_flip,
  output aatm_pkg::side_t                out_side
);
  import aatm_pkg::*;

  localparam int AW = 62 - FRAC_BITS;
  localparam int K  = AW - 33;
  localparam int RW = AW + 3;
  localparam int NS = K + 2;
  localparam logic [RW-1:0] TP = RW'(TWO_PI_Q30);
  localparam logic signed [ZW-1:0] TP_Z   = ZW'(TWO_PI_Q30);
  localparam logic signed [ZW-1:0] PI_Z   = ZW'(PI_Q30);
  localparam logic signed [ZW-1:0] HPI_Z  = ZW'(HALF_PI_Q30);

  logic [RW-1:0] v_r   [NS];
  logic          vld_r [NS];
  side_t         side_r[NS];

  logic [AW-1:0] a_q30;
  logic [RW-1:0] a_ext;
  logic [RW-1:0] v0_nxt;

  assign a_q30  = {in_angle, {(30 - FRAC_BITS){1'b0}}};
  assign a_ext  = {{3{a_q30[AW-1]}}, a_q30};
  assign v0_nxt = a_q30[AW-1] ? a_ext + (TP << K) : a_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
    if (en) begin
      v_r[0]    <= v0_nxt;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 1; s < NS; s++) begin : g_step
    localparam logic [RW-1:0] STEP = TP << (K + 1 - s);
    logic [RW-1:0] diff;
    logic [RW-1:0] v_nxt;
    assign diff  = v_r[s-1] - STEP;
    assign v_nxt = (v_r[s-1] >= STEP) ? diff : v_r[s-1];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
      if (en) begin
        v_r[s]    <= v_nxt;
        side_r[s] <= side_r[s-1];
      end
    end
  end

  logic signed [ZW-1:0] vs;
  logic signed [ZW-1:0] w_nxt;
  logic signed [ZW-1:0] w_r;
  logic                 wvld_r;
  side_t                wside_r;

  assign vs    = $signed(v_r[NS-1][ZW-1:0]);
  assign w_nxt = (vs > PI_Z) ? vs - TP_Z : vs;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvld_r <= 1'b0;
    end else if (en) begin
      wvld_r <= vld_r[NS-1];
    end
    if (en) begin
      w_r     <= w_nxt;
      wside_r <= side_r[NS-1];
    end
  end

  logic signed [ZW-1:0] z_nxt;
  logic                 flip_nxt;
  logic signed [ZW-1:0] z_r;
  logic                 flip_r;
  logic                 zvld_r;
  side_t                zside_r;

  always_comb begin
    if (w_r > HPI_Z) begin
      z_nxt    = PI_Z - w_r;
      flip_nxt = 1'b1;
    end else if (w_r < -HPI_Z) begin
      z_nxt    = -PI_Z - w_r;
      flip_nxt = 1'b1;
    end else begin
      z_nxt    = w_r;
      flip_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zvld_r <= 1'b0;
    end else if (en) begin
      zvld_r <= wvld_r;
    end
    if (en) begin
      z_r     <= z_nxt;
      flip_r  <= flip_nxt;
      zside_r <= wside_r;
    end
  end

  assign out_vld  = zvld_r;
  assign out_z    = z_r;
  assign out_flip = flip_r;
  assign out_side = zside_r;

endmodule

FILE: sv/aatm_cordic.sv
// ----------------------------------------------------------------------------
// aatm_cordic
// Rotation-mode CORDIC, one iteration per pipeline stage.
// ----------------------------------------------------------------------------
module aatm_cordic #(
  parameter int CORDIC_STEPS = aatm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic signed [aatm_pkg::ZW-1:0] in_z,
  input  logic                           in_flip,
  input  aatm_pkg::side_t                in_side,
  output logic                           out_vld,
  output logic signed [aatm_pkg::CW-1:0] out_x,
  output logic signed [aatm_pkg::CW-1:0] out_y,
  output logic                           out_flip,
  output aatm_pkg::side_t                out_side
);
  import aatm_pkg::*;

  localparam int N = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

  logic signed [CW-1:0] x_r   [N];
  logic signed [CW-1:0] y_r   [N];
  logic signed [ZW-1:0] z_r   [N];
  logic                 flip_r[N];
  logic                 vld_r [N];
  side_t                side_r[N];

  for (genvar i = 0; i < N; i++) begin : g_iter
    localparam logic signed [ZW-1:0] ATAN_I = ZW'(ATAN_Q30[i]);
    logic signed [CW-1:0] sx;
    logic signed [CW-1:0] sy;
    logic signed [ZW-1:0] sz;
    logic                 sflip;
    logic                 svld;
    side_t                sside;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    if (i == 0) begin : g_first
      assign sx    = CW'(GAIN_Q30);
      assign sy    = '0;
      assign sz    = in_z;
      assign sflip = in_flip;
      assign svld  = in_vld;
      assign sside = in_side;
    end else begin : g_next
      assign sx    = x_r[i-1];
      assign sy    = y_r[i-1];
      assign sz    = z_r[i-1];
      assign sflip = flip_r[i-1];
      assign svld  = vld_r[i-1];
      assign sside = side_r[i-1];
    end

    assign dx = sy >>> i;
    assign dy = sx >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= svld;
      end
      if (en) begin
        if (!sz[ZW-1]) begin
          x_r[i] <= sx - dx;
          y_r[i] <= sy + dy;
          z_r[i] <= sz - ATAN_I;
        end else begin
          x_r[i] <= sx + dx;
          y_r[i] <= sy - dy;
          z_r[i] <= sz + ATAN_I;
        end
        flip_r[i] <= sflip;
        side_r[i] <= sside;
      end
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_x    = x_r[N-1];
  assign out_y    = y_r[N-1];
  assign out_flip = flip_r[N-1];
  assign out_side = side_r[N-1];

endmodule

FILE: sv/aatm_matrix.sv
// ----------------------------------------------------------------------------
// aatm_matrix
// Rodrigues rotation terms, scaling and saturation over five pipeline stages.
// ----------------------------------------------------------------------------
module aatm_matrix (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic signed [aatm_pkg::CW-1:0] in_x,
  input  logic signed [aatm_pkg::CW-1:0] in_y,
  input  logic                           in_flip,
  input  aatm_pkg::side_t                in_side,
  output logic                           out_vld,
  output aatm_pkg::mat_t                 out_mat
);
  import aatm_pkg::*;

  localparam int PA [6] = '{0, 1, 2, 0, 1, 0};
  localparam int PB [6] = '{0, 1, 2, 1, 2, 2};
  localparam logic signed [TW-1:0] ONE_T = TW'(ONE_Q30);
  localparam logic signed [66:0] RND_TT = 67'sd1 <<< 27;
  localparam logic signed [49:0] RND_SK = 50'sd1 <<< 13;
  localparam logic signed [38:0] RND_R  = 39'sd2;
  localparam logic signed [68:0] RND_E  = 69'sd1 <<< 27;
  localparam logic signed [40:0] MAX_E  = 41'sd2147483647;
  localparam logic signed [40:0] MIN_E  = -41'sd2147483648;

  // Stage 1: cosine sign, t = 1 - cos, axis products.
  logic                 v1_r;
  side_t                side1_r;
  logic signed [CW-1:0] sn1_r;
  logic signed [CW-1:0] cs1_r;
  logic signed [TW-1:0] t1_r;
  logic signed [31:0]   p1_r [6];
  logic signed [CW-1:0] cs_nxt;
  logic signed [TW-1:0] t_nxt;

  assign cs_nxt = in_flip ? -in_x : in_x;
  assign t_nxt  = ONE_T - cs_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
    if (en) begin
      side1_r <= in_side;
      sn1_r   <= in_y;
      cs1_r   <= cs_nxt;
      t1_r    <= t_nxt;
    end
  end

  for (genvar q = 0; q < 6; q++) begin : g_p
    logic signed [31:0] p_nxt;
    assign p_nxt = $signed(in_side.axis[PA[q]]) * $signed(in_side.axis[PB[q]]);
    always_ff @(posedge clk) begin
      if (en) begin
        p1_r[q] <= p_nxt;
      end
    end
  end

  // Stage 2: t * a_i * a_j and sin * a_k, rounded to Q30.
  logic                 v2_r;
  side_t                side2_r;
  logic signed [CW-1:0] cs2_r;
  logic signed [37:0]   tt2_r [6];
  logic signed [35:0]   sk2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= v1_r;
    end
    if (en) begin
      side2_r <= side1_r;
      cs2_r   <= cs1_r;
    end
  end

  for (genvar q = 0; q < 6; q++) begin : g_tt
    logic signed [66:0] pt;
    logic signed [66:0] ptr;
    assign pt  = p1_r[q] * t1_r;
    assign ptr = pt + RND_TT;
    always_ff @(posedge clk) begin
      if (en) begin
        tt2_r[q] <= ptr[65:28];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_sk
    logic signed [49:0] sa;
    logic signed [49:0] sar;
    assign sa  = sn1_r * $signed(side1_r.axis[k]);
    assign sar = sa + RND_SK;
    always_ff @(posedge clk) begin
      if (en) begin
        sk2_r[k] <= sar[49:14];
      end
    end
  end

  // Stage 3: rotation entries, rounded to Q28.
  logic                 v3_r;
  side_t                side3_r;
  logic signed [36:0]   r28_r [3][3];
  logic signed [38:0]   rot   [3][3];

  always_comb begin
    rot[0][0] = cs2_r + tt2_r[0];
    rot[1][1] = cs2_r + tt2_r[1];
    rot[2][2] = cs2_r + tt2_r[2];
    rot[0][1] = tt2_r[3] + sk2_r[2];
    rot[1][0] = tt2_r[3] - sk2_r[2];
    rot[1][2] = tt2_r[4] + sk2_r[0];
    rot[2][1] = tt2_r[4] - sk2_r[0];
    rot[2][0] = tt2_r[5] + sk2_r[1];
    rot[0][2] = tt2_r[5] - sk2_r[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en) begin
      v3_r <= v2_r;
    end
    if (en) begin
      side3_r <= side2_r;
    end
  end

  // Stage 4: multiply by the column scale. Stage 5: round and saturate.
  logic                 v4_r;
  side_t                side4_r;
  logic signed [68:0]   prod4_r [3][3];
  logic                 v5_r;
  mat_t                 mat5_r;

  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      logic signed [38:0] rr;
      logic signed [68:0] prod;
      logic signed [68:0] pr;
      logic signed [40:0] ev;
      logic signed [31:0] e_nxt;
      assign rr   = rot[i][j] + RND_R;
      assign prod = r28_r[i][j] * $signed(side3_r.scale[j]);
      assign pr   = prod4_r[i][j] + RND_E;
      assign ev   = pr[68:28];
      always_comb begin
        if (ev > MAX_E) begin
          e_nxt = 32'sh7FFFFFFF;
        end else if (ev < MIN_E) begin
          e_nxt = 32'sh80000000;
        end else begin
          e_nxt = ev[31:0];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          r28_r[i][j]    <= rr[38:2];
          prod4_r[i][j]  <= prod;
          mat5_r.e[i][j] <= e_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
    if (en) begin
      side4_r      <= side3_r;
      mat5_r.shift <= side4_r.shift;
    end
  end

  assign out_vld = v5_r;
  assign out_mat = mat5_r;

endmodule

FILE: sv/aatm_rows.sv
// ----------------------------------------------------------------------------
// aatm_rows
// Output register that sends one finished matrix as four row transactions.
// ----------------------------------------------------------------------------
module aatm_rows #(
  parameter int FRAC_BITS = aatm_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  aatm_pkg::mat_t        in_mat,
  output logic                  adv,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_row_index,
  output logic [31:0]           out_col0,
  output logic [31:0]           out_col1,
  output logic [31:0]           out_col2,
  output logic [31:0]           out_col3,
  output logic                  out_last_row
);
  import aatm_pkg::*;

  localparam logic [31:0] ONE_F = 32'd1 << FRAC_BITS;

  logic  busy_r;
  row_t  row_r;
  mat_t  mat_r;
  logic  take;
  logic  load;

  assign take = busy_r && out_ready;
  assign load = in_vld && (!busy_r || (take && row_r == ROW_T));
  assign adv  = !in_vld || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= ROW_0;
    end else if (load) begin
      busy_r <= 1'b1;
      row_r  <= ROW_0;
    end else if (take) begin
      if (row_r == ROW_T) begin
        busy_r <= 1'b0;
      end
      row_r <= row_t'(row_r + 2'd1);
    end
    if (load) begin
      mat_r <= in_mat;
    end
  end

  always_comb begin
    case (row_r)
      ROW_0: begin
        out_col0 = mat_r.e[0][0];
        out_col1 = mat_r.e[0][1];
        out_col2 = mat_r.e[0][2];
        out_col3 = '0;
      end
      ROW_1: begin
        out_col0 = mat_r.e[1][0];
        out_col1 = mat_r.e[1][1];
        out_col2 = mat_r.e[1][2];
        out_col3 = '0;
      end
      ROW_2: begin
        out_col0 = mat_r.e[2][0];
        out_col1 = mat_r.e[2][1];
        out_col2 = mat_r.e[2][2];
        out_col3 = '0;
      end
      default: begin
        out_col0 = mat_r.shift[0];
        out_col1 = mat_r.shift[1];
        out_col2 = mat_r.shift[2];
        out_col3 = ONE_F;
      end
    endcase
  end

  assign out_valid     = busy_r;
  assign out_row_index = row_r;
  assign out_last_row  = (row_r == ROW_T);

endmodule

FILE: tb/sv/axis_angle_transform_matrix_tb.sv
// ----------------------------------------------------------------------------
// axis_angle_transform_matrix_tb
// Self-checking testbench for the axis-angle transform matrix block.
// ----------------------------------------------------------------------------
// Directed transforms cover field extremes, axis-aligned and non-unit axes and
// angles around the fold points, then random transforms run under several
// idle and stall phases. Every matrix row is predicted and checked in order.
// ----------------------------------------------------------------------------
module axis_angle_transform_matrix_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import aatm_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int STEPS = CORDIC_STEPS_DEF;

  typedef struct {
    logic [1:0]  row;
    logic [31:0] c0, c1, c2, c3;
    logic        last;
  } matrix_row_t;

  typedef struct {
    logic [31:0] sc [3];
    logic [31:0] sh [3];
    logic [15:0] ax [3];
    logic [31:0] ang;
  } xform_t;

  function automatic longint asr_l(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  class matrix_scoreboard;
    matrix_row_t pending[$];
    int errors;
    int rows_seen;

    function void sin_cos(longint a, output longint sn, output longint cs);
      longint r, x, y, z, dx, dy;
      bit flip;
      r = a * (longint'(1) << (30 - FRAC));
      r = r % TWO_PI_Q30;
      if (r < 0) r += TWO_PI_Q30;
      if (r > PI_Q30) r -= TWO_PI_Q30;
      flip = 0;
      if (r > HALF_PI_Q30) begin
        r = PI_Q30 - r;
        flip = 1;
      end else if (r < -HALF_PI_Q30) begin
        r = -PI_Q30 - r;
        flip = 1;
      end
      x = GAIN_Q30;
      y = 0;
      z = r;
      for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
        dx = asr_l(y, i);
        dy = asr_l(x, i);
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
        end
      end
      sn = y;
      cs = flip ? -x : x;
    endfunction

    function void note_transform(xform_t t);
      longint sc[3], ax[3], sk[3], tt[3][3], rot[3][3];
      longint sn, cs, om, r28;
      matrix_row_t m;
      for (int i = 0; i < 3; i++) begin
        sc[i] = longint'($signed(t.sc[i]));
        ax[i] = longint'($signed(t.ax[i]));
      end
      sin_cos(longint'($signed(t.ang)), sn, cs);
      om = ONE_Q30 - cs;
      for (int i = 0; i < 3; i++) begin
        sk[i] = round_shift(sn * ax[i], 14);
        for (int j = 0; j < 3; j++) tt[i][j] = round_shift(ax[i] * ax[j] * om, 28);
      end
      rot[0][0] = cs + tt[0][0];
      rot[1][1] = cs + tt[1][1];
      rot[2][2] = cs + tt[2][2];
      rot[0][1] = tt[0][1] + sk[2];
      rot[1][0] = tt[0][1] - sk[2];
      rot[1][2] = tt[1][2] + sk[0];
      rot[2][1] = tt[1][2] - sk[0];
      rot[2][0] = tt[0][2] + sk[1];
      rot[0][2] = tt[0][2] - sk[1];
      for (int i = 0; i < 3; i++) begin
        logic [31:0] e [3];
        for (int j = 0; j < 3; j++) begin
          r28 = round_shift(rot[i][j], 2);
          e[j] = 32'(clamp32(round_shift(r28 * sc[j], 28)));
        end
        m.row = 2'(i);
        m.c0 = e[0]; m.c1 = e[1]; m.c2 = e[2]; m.c3 = '0; m.last = 1'b0;
        pending.push_back(m);
      end
      m.row = ROW_T;
      m.c0 = t.sh[0]; m.c1 = t.sh[1]; m.c2 = t.sh[2];
      m.c3 = 32'(longint'(1) << FRAC);
      m.last = 1'b1;
      pending.push_back(m);
    endfunction

    function void check_row(matrix_row_t got);
      matrix_row_t exp_row;
      rows_seen++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected row %0d", $realtime, got.row);
        errors++;
        return;
      end
      exp_row = pending.pop_front();
      if (got.row !== exp_row.row || got.c0 !== exp_row.c0 || got.c1 !== exp_row.c1 ||
          got.c2 !== exp_row.c2 || got.c3 !== exp_row.c3 || got.last !== exp_row.last) begin
        $display("%0t: mismatch expected row %0d %h %h %h %h last %b", $realtime,
                 exp_row.row, exp_row.c0, exp_row.c1, exp_row.c2, exp_row.c3, exp_row.last);
        $display("%0t:          actual   row %0d %h %h %h %h last %b", $realtime,
                 got.row, got.c0, got.c1, got.c2, got.c3, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_scale_x = '0, in_scale_y = '0, in_scale_z = '0;
  logic [31:0] in_shift_x = '0, in_shift_y = '0, in_shift_z = '0;
  logic [15:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0;
  logic [31:0] in_angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_row_index;
  logic [31:0] out_col0, out_col1, out_col2, out_col3;
  logic out_last_row;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;
  matrix_scoreboard board = new();

  always #1 clk = ~clk;

  axis_angle_transform_matrix uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_scale_x(in_scale_x), .in_scale_y(in_scale_y), .in_scale_z(in_scale_z),
    .in_shift_x(in_shift_x), .in_shift_y(in_shift_y), .in_shift_z(in_shift_z),
    .in_axis_x(in_axis_x), .in_axis_y(in_axis_y), .in_axis_z(in_axis_z),
    .in_angle(in_angle),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_row_index(out_row_index), .out_col0(out_col0), .out_col1(out_col1),
    .out_col2(out_col2), .out_col3(out_col3), .out_last_row(out_last_row)
  );

  always @(posedge clk) begin
    matrix_row_t got;
    if (rst_n && out_valid && out_ready) begin
      got.row = out_row_index;
      got.c0 = out_col0; got.c1 = out_col1; got.c2 = out_col2; got.c3 = out_col3;
      got.last = out_last_row;
      board.check_row(got);
    end
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_transform(xform_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_scale_x <= t.sc[0]; in_scale_y <= t.sc[1]; in_scale_z <= t.sc[2];
    in_shift_x <= t.sh[0]; in_shift_y <= t.sh[1]; in_shift_z <= t.sh[2];
    in_axis_x <= t.ax[0]; in_axis_y <= t.ax[1]; in_axis_z <= t.ax[2];
    in_angle <= t.ang;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_transform(t);
    sent++;
  endtask

  function automatic logic [31:0] rand_scale();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
    endcase
  endfunction

  function automatic logic [15:0] rand_axis_val();
    case ($urandom_range(4))
      0: return 16'($signed($urandom_range(32768)) - 16384);
      1: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
      2: return 16'h0;
      default: return 16'($signed($urandom_range(20000)) - 10000);
    endcase
  endfunction

  function automatic xform_t rand_transform();
    xform_t t;
    for (int i = 0; i < 3; i++) begin
      t.sc[i] = rand_scale();
      t.sh[i] = $urandom();
      t.ax[i] = rand_axis_val();
    end
    // Most angles stay within a few turns; some use the full range.
    if ($urandom_range(3) == 0) t.ang = $urandom();
    else t.ang = 32'($signed($urandom_range(32 << 16)) - (16 << 16));
    return t;
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    xform_t t;
    int angles [12];
    angles = '{0, 1, -1, 102944, -102944, 102943, 205887, -205887, 205888,
               411775, 32'h7FFF_FFFF, 32'h8000_0000};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    out_ready <= 1'b1;
    @(posedge clk);
    // Directed: axis-aligned rotations, fold points, extremes and non-unit axes.
    for (int k = 0; k < 12; k++) begin
      for (int i = 0; i < 3; i++) begin
        t.sc[i] = 32'h0001_0000;
        t.sh[i] = 32'(k * 1000 - i);
        t.ax[i] = (i == k % 3) ? 16'sd16384 : 16'sd0;
      end
      t.ang = angles[k];
      send_transform(t);
    end
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 3; i++) begin
        t.sc[i] = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
        t.sh[i] = k[1] ? 32'h7FFF_FFFF : 32'h8000_0000;
        t.ax[i] = k[2] ? -16'sd16384 : (k[1] ? 16'hFFFF : 16'sd16384);
      end
      t.ang = k[0] ? 32'hFFFF_FFFF : 32'h5555_5555;
      send_transform(t);
    end
    wait_drained();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      for (int n = 0; n < 103; n++) begin
        send_transform(rand_transform());
        if (n == 50) wait_drained();
      end
    end
    wait_drained();
    repeat (60) @(posedge clk);
    $display("Ran %0d transforms (%0d rows checked) through idle and stall phases.",
             sent, board.rows_seen);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("axis_angle_transform_matrix_tb passed");
    else
      $display("axis_angle_transform_matrix_tb failed");
    $finish;
  end

  initial begin
    #200000;
    $display("Timeout with %0d rows outstanding.", board.pending.size());
    $display("axis_angle_transform_matrix_tb failed");
    $finish;
  end
endmodule

FILE: files.f
sv/aatm_pkg.sv
sv/aatm_reduce.sv
sv/aatm_cordic.sv
sv/aatm_matrix.sv
sv/aatm_rows.sv
sv/axis_angle_transform_matrix.sv
tb/sv/axis_angle_transform_matrix_tb.sv
